### rtl/flp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flp_pkg: shared definitions for the four-pole ladder low-pass filter
// Widths, operation codes and the controller-to-datapath command word.
// ----------------------------------------------------------------------------
package flp_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CTRL_W   = 16;
  localparam int STATE_W  = 24;

  localparam int OP_W = 5;

  // One code per product in the sequence; the datapath picks operands and
  // the writeback target from it.
  localparam logic [OP_W-1:0] OP_T1    = 5'd0;
  localparam logic [OP_W-1:0] OP_P     = 5'd1;
  localparam logic [OP_W-1:0] OP_U     = 5'd2;
  localparam logic [OP_W-1:0] OP_INNER = 5'd3;
  localparam logic [OP_W-1:0] OP_G     = 5'd4;
  localparam logic [OP_W-1:0] OP_QK    = 5'd5;
  localparam logic [OP_W-1:0] OP_FIN   = 5'd6;
  localparam logic [OP_W-1:0] OP_S1A   = 5'd7;
  localparam logic [OP_W-1:0] OP_S1B   = 5'd8;
  localparam logic [OP_W-1:0] OP_S2A   = 5'd9;
  localparam logic [OP_W-1:0] OP_S2B   = 5'd10;
  localparam logic [OP_W-1:0] OP_S3A   = 5'd11;
  localparam logic [OP_W-1:0] OP_S3B   = 5'd12;
  localparam logic [OP_W-1:0] OP_S4A   = 5'd13;
  localparam logic [OP_W-1:0] OP_S4B   = 5'd14;
  localparam logic [OP_W-1:0] OP_SQ    = 5'd15;
  localparam logic [OP_W-1:0] OP_CUBE  = 5'd16;
  localparam logic [OP_W-1:0] OP_CLIP  = 5'd17;

  localparam logic [OP_W-1:0] OP_FIRST = OP_T1;
  localparam logic [OP_W-1:0] OP_LAST  = OP_CLIP;

  typedef struct packed {
    logic            capture;
    logic            issue;
    logic            wb;
    logic            out_load;
    logic [OP_W-1:0] op;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/flp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flp_ctrl: sequencer for the ladder filter
// Walks the product sequence, issuing a multiply and then a writeback for each
// operation, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module flp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          bypass,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output flp_pkg::cmd_t cmd
);
  import flp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [OP_W-1:0] op_r, op_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.op        = op_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          op_nxt      = OP_FIRST;
          state_nxt   = bypass ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.issue = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        cmd.wb = 1'b1;
        if (op_r == OP_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          op_nxt    = op_r + OP_W'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        // The output word may only be replaced once the old one is taken.
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### rtl/flp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flp_dp: datapath for the ladder filter
// One shared signed multiplier with a registered product, operand selection
// and writeback by operation code, filter state and the output register.
// ----------------------------------------------------------------------------
module flp_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  flp_pkg::cmd_t                        cmd,
  input  logic                                 bypass,
  input  logic signed [flp_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic        [flp_pkg::CTRL_W-1:0]    in_cutoff,
  input  logic        [flp_pkg::CTRL_W-1:0]    in_resonance,
  output logic signed [flp_pkg::SAMPLE_W-1:0]  out_sample_out
);
  import flp_pkg::*;

  localparam int DP_W        = 32;
  localparam int PROD_W      = 2 * DP_W;
  localparam int COEF_FRAC   = 20;
  localparam int STATE_FRAC  = STATE_W - 4;
  localparam int SAMPLE_FRAC = SAMPLE_W - 1;
  localparam int FREQ_SH     = COEF_FRAC - CTRL_W - 2;
  localparam int RES_SH      = COEF_FRAC - CTRL_W;
  localparam int XS_SH       = STATE_FRAC - SAMPLE_FRAC;

  localparam logic signed [DP_W-1:0] COEF_ONE = DP_W'(1) << COEF_FRAC;
  localparam logic signed [DP_W-1:0] K_0P8    = DP_W'(838861);
  localparam logic signed [DP_W-1:0] K_5P6    = DP_W'(5872026);
  localparam logic signed [DP_W-1:0] K_SIXTH  = DP_W'(174763);

  function automatic logic signed [DP_W-1:0] sx_state(input logic signed [STATE_W-1:0] v);
    return {{(DP_W-STATE_W){v[STATE_W-1]}}, v};
  endfunction

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [DP_W-1:0] v);
    logic [DP_W-STATE_W:0] hi;
    hi = v[DP_W-1:STATE_W-1];
    if (hi == '0 || hi == '1) begin
      return v[STATE_W-1:0];
    end else if (v[DP_W-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [STATE_W-1:0] v
  );
    logic [STATE_W-SAMPLE_W:0] hi;
    hi = v[STATE_W-1:SAMPLE_W-1];
    if (hi == '0 || hi == '1) begin
      return v[SAMPLE_W-1:0];
    end else if (v[STATE_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

  // Captured word.
  logic signed [SAMPLE_W-1:0] sample_r;
  logic        [CTRL_W-1:0]   cut_r;
  logic        [CTRL_W-1:0]   res_r;

  // Working registers.
  logic signed [DP_W-1:0]    p_r;
  logic signed [DP_W-1:0]    tmp_r;
  logic signed [DP_W-1:0]    acc_r;
  logic signed [STATE_W-1:0] fin_r;
  logic signed [STATE_W-1:0] old_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SAMPLE_W-1:0] out_r;

  // Filter state.
  logic signed [STATE_W-1:0] prev_r;
  logic signed [STATE_W-1:0] s1_r;
  logic signed [STATE_W-1:0] s2_r;
  logic signed [STATE_W-1:0] s3_r;
  logic signed [STATE_W-1:0] s4_r;

  logic signed [DP_W-1:0]   freq_w, q0_w, res_w, xs_w, f_w;
  logic signed [DP_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] sh20_w, sh21_w;
  logic signed [DP_W-1:0]   m20_w, m21_w;
  logic signed [STATE_W-1:0] stage_w;
  logic signed [STATE_W-1:0] y_w;

  assign freq_w = $signed({{(DP_W-CTRL_W){1'b0}}, cut_r}) <<< FREQ_SH;
  assign q0_w   = COEF_ONE - freq_w;
  assign res_w  = $signed({{(DP_W-CTRL_W){1'b0}}, res_r}) <<< RES_SH;
  assign xs_w   = $signed({{(DP_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r}) <<< XS_SH;
  assign f_w    = (p_r <<< 1) - COEF_ONE;

  // Arithmetic shifts of the product give floor rounding.
  assign sh20_w = prod_r >>> COEF_FRAC;
  assign sh21_w = prod_r >>> (COEF_FRAC + 1);
  assign m20_w  = sh20_w[DP_W-1:0];
  assign m21_w  = sh21_w[DP_W-1:0];

  assign stage_w = sat_state(acc_r - m20_w);
  assign y_w     = s4_r >>> XS_SH;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_T1: begin
        mul_a = freq_w;
        mul_b = q0_w;
      end
      OP_P: begin
        mul_a = tmp_r;
        mul_b = K_0P8;
      end
      OP_U: begin
        mul_a = K_5P6;
        mul_b = q0_w;
      end
      OP_INNER: begin
        mul_a = tmp_r;
        mul_b = q0_w;
      end
      OP_G: begin
        mul_a = q0_w;
        mul_b = tmp_r;
      end
      OP_QK: begin
        mul_a = res_w;
        mul_b = tmp_r;
      end
      OP_FIN: begin
        mul_a = tmp_r;
        mul_b = sx_state(s4_r);
      end
      OP_S1A: begin
        mul_a = sx_state(fin_r) + sx_state(prev_r);
        mul_b = p_r;
      end
      OP_S1B: begin
        mul_a = sx_state(s1_r);
        mul_b = f_w;
      end
      OP_S2A: begin
        mul_a = sx_state(s1_r) + sx_state(old_r);
        mul_b = p_r;
      end
      OP_S2B: begin
        mul_a = sx_state(s2_r);
        mul_b = f_w;
      end
      OP_S3A: begin
        mul_a = sx_state(s2_r) + sx_state(old_r);
        mul_b = p_r;
      end
      OP_S3B: begin
        mul_a = sx_state(s3_r);
        mul_b = f_w;
      end
      OP_S4A: begin
        mul_a = sx_state(s3_r) + sx_state(old_r);
        mul_b = p_r;
      end
      OP_S4B: begin
        mul_a = sx_state(s4_r);
        mul_b = f_w;
      end
      OP_SQ: begin
        mul_a = tmp_r;
        mul_b = tmp_r;
      end
      OP_CUBE: begin
        mul_a = acc_r;
        mul_b = tmp_r;
      end
      OP_CLIP: begin
        mul_a = acc_r;
        mul_b = K_SIXTH;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample_in;
      cut_r    <= in_cutoff;
      res_r    <= in_resonance;
    end
    if (cmd.issue) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.wb) begin
      case (cmd.op)
        OP_T1:    tmp_r <= m20_w;
        OP_P:     p_r   <= freq_w + m20_w;
        OP_U:     tmp_r <= m20_w;
        OP_INNER: tmp_r <= freq_w + m20_w;
        OP_G:     tmp_r <= COEF_ONE + m21_w;
        OP_QK:    tmp_r <= m20_w;
        OP_FIN:   fin_r <= sat_state(xs_w - m20_w);
        OP_S1A, OP_S2A, OP_S3A, OP_S4A: acc_r <= m20_w;
        OP_S1B:   old_r <= s1_r;
        OP_S2B:   old_r <= s2_r;
        OP_S3B:   old_r <= s3_r;
        // The last stage before the soft clip is held in tmp_r.
        OP_S4B:   tmp_r <= sx_state(stage_w);
        OP_SQ:    acc_r <= m20_w;
        OP_CUBE:  acc_r <= m20_w;
        default: begin
        end
      endcase
    end
    if (cmd.out_load) begin
      out_r <= bypass ? sample_r : sat_sample(y_w);
    end
  end

  // Filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      s1_r   <= '0;
      s2_r   <= '0;
      s3_r   <= '0;
      s4_r   <= '0;
    end else if (cmd.wb) begin
      case (cmd.op)
        OP_S1B: s1_r <= stage_w;
        OP_S2B: s2_r <= stage_w;
        OP_S3B: s3_r <= stage_w;
        OP_CLIP: begin
          s4_r   <= sat_state(tmp_r - m20_w);
          prev_r <= fin_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_sample_out = out_r;

endmodule
`default_nettype wire

### rtl/four_pole_ladder_lowpass.sv
// A new word is taken only when the sequencer is idle, so each sample finishes before the next
// is accepted; its 18 products go one at a time through the single shared 32x32 multiplier,
// each as a multiply followed by a writeback. With bypass, the products are skipped.
// Results wait in an output register, so the next word is taken while one is pending.
// Reset: synchronous, active low; clears the ladder state, the bypass bit and the handshakes.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_pole_ladder_lowpass: resonant four-pole ladder low-pass filter
// Sequencer plus shared-multiplier datapath, with the bypass register.
// ----------------------------------------------------------------------------
module four_pole_ladder_lowpass (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic                                 cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [flp_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic        [flp_pkg::CTRL_W-1:0]    in_cutoff,
  input  logic        [flp_pkg::CTRL_W-1:0]    in_resonance,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [flp_pkg::SAMPLE_W-1:0]  out_sample_out
);
  import flp_pkg::*;

  logic bypass_r;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b0;
    end else if (cfg_wr_en) begin
      bypass_r <= cfg_wr_data;
    end
  end

  flp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .bypass    (bypass_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  flp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .bypass         (bypass_r),
    .in_sample_in   (in_sample_in),
    .in_cutoff      (in_cutoff),
    .in_resonance   (in_resonance),
    .out_sample_out (out_sample_out)
  );

endmodule
`default_nettype wire
